### rtl/alru_pkg.sv
package alru_pkg;

  localparam int ENTRIES    = 32;
  localparam int INTERFACES = 8;
  localparam int STAMP_BITS = 32;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int IFC_W  = 3;
  localparam int KEY_W  = 32;
  localparam int HW_W   = 48;
  localparam int SLOT_W = 5;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_FILL   = 1'b1;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } alru_state_t;

  // request fields broadcast to every cell during the search
  typedef struct packed {
    logic             cmd;
    logic [IFC_W-1:0] ifc;
    logic [KEY_W-1:0] key;
    logic             ifc_ok;
  } req_t;

  // running search result handed from cell to cell
  typedef struct packed {
    logic            hit;
    logic            empty_found;
    logic            have_best;
    stamp_t          best_stamp;
    idx_t            idx;
    logic [HW_W-1:0] hw;
  } link_t;

  // entry update broadcast from the top level
  typedef struct packed {
    logic             fill_en;
    logic             touch_en;
    idx_t             idx;
    logic [IFC_W-1:0] ifc;
    logic [KEY_W-1:0] key;
    logic [HW_W-1:0]  hw;
    stamp_t           stamp;
  } wr_t;

endpackage

### rtl/alru_cell.sv
module alru_cell
  import alru_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  idx_t  cell_idx,
  input  req_t  req,
  input  wr_t   wr,
  input  logic  prev_vld,
  input  link_t prev_link,
  output logic  next_vld,
  output link_t next_link
);

  logic             valid_r;
  logic [IFC_W-1:0] ifc_r;
  logic [KEY_W-1:0] key_r;
  logic [HW_W-1:0]  hw_r;
  stamp_t           stamp_r;

  logic  vld_r;
  link_t link_r;
  link_t link_nxt;

  logic sel;
  assign sel = (wr.idx == cell_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr.fill_en && sel) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.fill_en && sel) begin
      ifc_r   <= wr.ifc;
      key_r   <= wr.key;
      hw_r    <= wr.hw;
      stamp_r <= wr.stamp;
    end else if (wr.touch_en && sel) begin
      stamp_r <= wr.stamp;
    end
  end

  always_comb begin
    link_nxt = prev_link;
    if (req.cmd == CMD_LOOKUP) begin
      if (!prev_link.hit && valid_r && req.ifc_ok && ifc_r == req.ifc && key_r == req.key) begin
        link_nxt.hit = 1'b1;
        link_nxt.idx = cell_idx;
        link_nxt.hw  = hw_r;
      end
    end else if (!prev_link.empty_found) begin
      if (!valid_r) begin
        link_nxt.empty_found = 1'b1;
        link_nxt.idx         = cell_idx;
      end else if (!prev_link.have_best || stamp_r < prev_link.best_stamp) begin
        link_nxt.have_best  = 1'b1;
        link_nxt.best_stamp = stamp_r;
        link_nxt.idx        = cell_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= prev_vld;
    end
  end

  always_ff @(posedge clk) begin
    link_r <= link_nxt;
  end

  assign next_vld  = vld_r;
  assign next_link = link_r;

endmodule

### rtl/address_cache_lru_core.sv
// An accepted request is registered, then its search token walks the cell chain
//   one entry per cycle, and the commit state writes the entry update and the result once
//   the output is free. No new request is accepted until the block is idle again.
// Reset (rst_n low, synchronous): all entries invalid, stamp counter zero,
//   no result pending. Entry contents are not cleared.
module address_cache_lru_core
  import alru_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_command,
  input  logic [IFC_W-1:0] in_interface_id,
  input  logic [KEY_W-1:0] in_proto_address,
  input  logic [HW_W-1:0]  in_fill_hw_address,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_hit,
  output logic [HW_W-1:0]  out_hw_address,
  output logic             out_stored,
  output logic [SLOT_W-1:0] out_slot
);

  alru_state_t state_r, state_nxt;

  req_t            req_r;
  logic [HW_W-1:0] req_hw_r;
  logic            start_r;
  link_t           tail_r;
  stamp_t          stamp_cnt_r;
  wr_t             wr;

  logic              out_valid_r;
  logic              out_hit_r;
  logic [HW_W-1:0]   out_hw_r;
  logic              out_stored_r;
  logic [SLOT_W-1:0] out_slot_r;

  logic  accept;
  logic  out_free;
  logic  commit;
  logic  do_touch;
  logic  do_fill;

  logic  chain_vld  [ENTRIES+1];
  link_t chain_link [ENTRIES+1];
  logic [ENTRIES:0] chain_vld_vec;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_SEARCH;
      ST_SEARCH: if (chain_vld[ENTRIES]) state_nxt = ST_COMMIT;
      ST_COMMIT: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    commit   = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_stall = 1'b0;
      ST_SEARCH: in_stall = 1'b1;
      ST_COMMIT: commit   = out_free;
      default:   in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.cmd    <= in_command;
      req_r.ifc    <= in_interface_id;
      req_r.key    <= in_proto_address;
      req_r.ifc_ok <= (32'(in_interface_id) < INTERFACES);
      req_hw_r     <= in_fill_hw_address;
    end
    if (chain_vld[ENTRIES]) begin
      tail_r <= chain_link[ENTRIES];
    end
  end

  assign chain_vld[0]  = start_r;
  assign chain_link[0] = '{hit: 1'b0, empty_found: 1'b0, have_best: 1'b0,
                           best_stamp: '0, idx: '0, hw: '0};

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    alru_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(g)),
      .req       (req_r),
      .wr        (wr),
      .prev_vld  (chain_vld[g]),
      .prev_link (chain_link[g]),
      .next_vld  (chain_vld[g+1]),
      .next_link (chain_link[g+1])
    );
  end

  for (genvar g = 0; g <= ENTRIES; g++) begin : g_vec
    assign chain_vld_vec[g] = chain_vld[g];
  end

  assign do_touch = commit && (req_r.cmd == CMD_LOOKUP) && tail_r.hit;
  assign do_fill  = commit && (req_r.cmd == CMD_FILL) && req_r.ifc_ok && (req_hw_r != '0);

  always_comb begin
    wr.fill_en  = do_fill;
    wr.touch_en = do_touch;
    wr.idx      = tail_r.idx;
    wr.ifc      = req_r.ifc;
    wr.key      = req_r.key;
    wr.hw       = req_hw_r;
    wr.stamp    = stamp_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_cnt_r <= '0;
    end else if (do_touch || do_fill) begin
      stamp_cnt_r <= stamp_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r    <= do_touch;
      out_hw_r     <= do_touch ? tail_r.hw : '0;
      out_stored_r <= do_fill;
      out_slot_r   <= (do_touch || do_fill) ? SLOT_W'(tail_r.idx) : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_hw_address = out_hw_r;
  assign out_stored     = out_stored_r;
  assign out_slot       = out_slot_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(chain_vld_vec))
    else $error("more than one request in the cell chain");

  a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    chain_vld[ENTRIES] |-> state_r == ST_SEARCH)
    else $error("chain tail valid outside search");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("commit did not load result");

  a_hit_xor_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_stored_r) && (out_hit_r || out_hw_r == '0))
    else $error("inconsistent result fields");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import alru_pkg::*;

  localparam int RANDOM_REQUESTS = 1283;
  localparam int QUIET_TAIL      = 150;
  localparam int HOLD_AFTER      = 600;
  localparam int HOLD_CYCLES     = 400;
  localparam int POOL_SIZE       = 48;
  localparam int DRAIN_CYCLES    = ENTRIES + 8;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DIRECTED_ROWS   = 17;

  localparam logic [KEY_W-1:0] KEY_ONES = '1;
  localparam logic [HW_W-1:0]  HW_ONES  = '1;
  localparam logic [HW_W-1:0]  HW_MSB   = 48'h8000_0000_0000;

  typedef struct {
    logic              hit;
    logic [HW_W-1:0]   hw;
    logic              stored;
    logic [SLOT_W-1:0] slot;
  } cache_reply_t;

  typedef struct packed {
    logic              cmd;
    logic [IFC_W-1:0]  ifc;
    logic [KEY_W-1:0]  key;
    logic [HW_W-1:0]   hw;
    logic              typed;
    logic              exp_hit;
    logic [HW_W-1:0]   exp_hw;
    logic              exp_stored;
    logic [SLOT_W-1:0] exp_slot;
  } directed_row_t;

  // rows marked typed carry their reply; the rest go through the predictor
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{CMD_LOOKUP, 3'd0, 32'h0,         48'h0,   1'b1, 1'b0, 48'h0,   1'b0, 5'd0},
    '{CMD_FILL,   3'd7, KEY_ONES,      HW_ONES, 1'b1, 1'b0, 48'h0,   1'b1, 5'd0},
    '{CMD_LOOKUP, 3'd7, KEY_ONES,      48'h0,   1'b1, 1'b1, HW_ONES, 1'b0, 5'd0},
    '{CMD_FILL,   3'd0, 32'h0,         48'h0,   1'b1, 1'b0, 48'h0,   1'b0, 5'd0},
    '{CMD_LOOKUP, 3'd0, 32'h0,         HW_ONES, 1'b1, 1'b0, 48'h0,   1'b0, 5'd0},
    '{CMD_FILL,   3'd0, 32'h0,         48'h1,   1'b1, 1'b0, 48'h0,   1'b1, 5'd1},
    '{CMD_LOOKUP, 3'd6, KEY_ONES,      48'h0,   1'b1, 1'b0, 48'h0,   1'b0, 5'd0},
    '{CMD_FILL,   3'd0, 32'h0,         48'h2,   1'b1, 1'b0, 48'h0,   1'b1, 5'd2},
    '{CMD_LOOKUP, 3'd0, 32'h0,         48'h0,   1'b1, 1'b1, 48'h1,   1'b0, 5'd1},
    '{CMD_FILL,   3'd3, 32'h1234_5678, HW_MSB,  1'b1, 1'b0, 48'h0,   1'b1, 5'd3},
    '{CMD_LOOKUP, 3'd3, 32'h1234_5678, 48'h0,   1'b1, 1'b1, HW_MSB,  1'b0, 5'd3},
    '{CMD_FILL,   3'd5, 32'hA5A5_A5A5, 48'h0,   1'b1, 1'b0, 48'h0,   1'b0, 5'd0},
    '{CMD_LOOKUP, 3'd5, 32'hA5A5_A5A5, 48'h0,   1'b1, 1'b0, 48'h0,   1'b0, 5'd0},
    '{CMD_LOOKUP, 3'd7, 32'hFFFF_FFFE, 48'h0,   1'b1, 1'b0, 48'h0,   1'b0, 5'd0},
    '{CMD_FILL,   3'd1, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF,
                                                1'b0, 1'b0, 48'h0,   1'b0, 5'd0},
    '{CMD_LOOKUP, 3'd1, 32'h7FFF_FFFF, 48'h0,   1'b0, 1'b0, 48'h0,   1'b0, 5'd0},
    '{CMD_LOOKUP, 3'd0, 32'h0,         48'h0,   1'b0, 1'b0, 48'h0,   1'b0, 5'd0}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_command = CMD_LOOKUP;
  logic [IFC_W-1:0]  in_interface_id = '0;
  logic [KEY_W-1:0]  in_proto_address = '0;
  logic [HW_W-1:0]   in_fill_hw_address = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_hit;
  logic [HW_W-1:0]   out_hw_address;
  logic              out_stored;
  logic [SLOT_W-1:0] out_slot;

  address_cache_lru_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_interface_id    (in_interface_id),
    .in_proto_address   (in_proto_address),
    .in_fill_hw_address (in_fill_hw_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hit            (out_hit),
    .out_hw_address     (out_hw_address),
    .out_stored         (out_stored),
    .out_slot           (out_slot)
  );

  always #5 clk = ~clk;

  logic             line_valid [ENTRIES];
  logic [IFC_W-1:0] line_ifc   [ENTRIES];
  logic [KEY_W-1:0] line_key   [ENTRIES];
  logic [HW_W-1:0]  line_hw    [ENTRIES];
  stamp_t           line_stamp [ENTRIES];
  stamp_t           stamp_next;

  cache_reply_t pending_replies [$];
  int  mismatch_count = 0;
  int  requests_sent = 0;
  int  cycle_count = 0;
  bit  quiet_tail = 1'b0;
  bit  hold_done = 1'b0;

  logic [IFC_W-1:0] pool_ifc [POOL_SIZE];
  logic [KEY_W-1:0] pool_key [POOL_SIZE];

  function automatic cache_reply_t cache_access(input logic cmd, input logic [IFC_W-1:0] ifc,
                                                input logic [KEY_W-1:0] key,
                                                input logic [HW_W-1:0] hw);
    cache_reply_t r;
    int victim;
    bit found_empty;
    bit ifc_ok;
    r = '{1'b0, '0, 1'b0, '0};
    victim = 0;
    found_empty = 1'b0;
    ifc_ok = int'(ifc) < INTERFACES;
    if (cmd == CMD_LOOKUP) begin
      if (ifc_ok) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (line_valid[i] && line_ifc[i] == ifc && line_key[i] == key) begin
            r.hit = 1'b1;
            r.hw = line_hw[i];
            r.slot = SLOT_W'(i);
            line_stamp[i] = stamp_next;
            stamp_next = stamp_next + 1'b1;
            break;
          end
        end
      end
    end else if (ifc_ok && hw != '0) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!line_valid[i]) begin
          victim = i;
          found_empty = 1'b1;
          break;
        end
      end
      if (!found_empty) begin
        for (int i = 1; i < ENTRIES; i++) begin
          if (line_stamp[i] < line_stamp[victim]) victim = i;
        end
      end
      line_valid[victim] = 1'b1;
      line_ifc[victim] = ifc;
      line_key[victim] = key;
      line_hw[victim] = hw;
      line_stamp[victim] = stamp_next;
      stamp_next = stamp_next + 1'b1;
      r.stored = 1'b1;
      r.slot = SLOT_W'(victim);
    end
    return r;
  endfunction

  task automatic issue_request(input logic cmd, input logic [IFC_W-1:0] ifc,
                               input logic [KEY_W-1:0] key, input logic [HW_W-1:0] hw,
                               input bit typed, input cache_reply_t typed_reply);
    cache_reply_t predicted;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_interface_id <= ifc;
    in_proto_address <= key;
    in_fill_hw_address <= hw;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = cache_access(cmd, ifc, key, hw);
    if (typed) begin
      pending_replies.push_back(typed_reply);
    end else begin
      pending_replies.push_back(predicted);
    end
    requests_sent++;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    cache_reply_t typed_reply;
    logic cmd;
    logic [IFC_W-1:0] ifc;
    logic [KEY_W-1:0] key;
    logic [HW_W-1:0] hw;
    int pick;
    foreach (line_valid[i]) line_valid[i] = 1'b0;
    stamp_next = '0;
    while (rst_n !== 1'b1) @(posedge clk);

    foreach (DIRECTED[i]) begin
      typed_reply = '{DIRECTED[i].exp_hit, DIRECTED[i].exp_hw,
                      DIRECTED[i].exp_stored, DIRECTED[i].exp_slot};
      issue_request(DIRECTED[i].cmd, DIRECTED[i].ifc, DIRECTED[i].key, DIRECTED[i].hw,
                    DIRECTED[i].typed, typed_reply);
    end

    // more pairs than entries, so fills keep evicting
    foreach (pool_key[i]) begin
      pool_ifc[i] = IFC_W'($urandom_range(0, INTERFACES - 1));
      pool_key[i] = $urandom;
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n >= RANDOM_REQUESTS - QUIET_TAIL) quiet_tail = 1'b1;
      cmd = ($urandom_range(0, 99) < 45) ? CMD_FILL : CMD_LOOKUP;
      if ($urandom_range(0, 99) < 85) begin
        pick = $urandom_range(0, POOL_SIZE - 1);
        ifc = pool_ifc[pick];
        key = pool_key[pick];
      end else begin
        ifc = IFC_W'($urandom);
        key = $urandom;
      end
      hw = HW_W'({$urandom, $urandom});
      if (cmd == CMD_FILL && $urandom_range(0, 19) == 0) hw = '0;
      issue_request(cmd, ifc, key, hw, 1'b0, typed_reply);
    end
    in_valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver: random stall bursts, one long hold-off mid-run, none at the tail
  initial begin
    int span;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!hold_done && requests_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        span = HOLD_CYCLES;
      end else if (quiet_tail) begin
        out_stall <= 1'b0;
        span = 1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 17);
      end else begin
        out_stall <= 1'b0;
        span = $urandom_range(1, 40);
      end
      repeat (span) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cache_reply_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: hit %0h hw_address %0h stored %0h slot %0d",
               out_hit, out_hw_address, out_stored, out_slot);
        mismatch_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_hit !== want.hit) begin
          $error("hit: expected %0h, got %0h", want.hit, out_hit);
          mismatch_count++;
        end
        if (out_hw_address !== want.hw) begin
          $error("hw_address: expected %0h, got %0h", want.hw, out_hw_address);
          mismatch_count++;
        end
        if (out_stored !== want.stored) begin
          $error("stored: expected %0h, got %0h", want.stored, out_stored);
          mismatch_count++;
        end
        if (out_slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_slot);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### filelist.f
rtl/alru_pkg.sv
rtl/alru_cell.sv
rtl/address_cache_lru_core.sv
tb/testbench.sv
